@@ rtl/sbsh_pkg.sv @@
// ----------------------------------------------------------------------------
// sbsh_pkg
// Shared types, constants and round functions of the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sbsh_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned DigestBytes = 32;

  typedef enum logic [1:0] {
    CMD_ABSORB        = 2'd0,
    CMD_ABSORB_FINISH = 2'd1,
    CMD_FINISH        = 2'd2,
    CMD_NONE          = 2'd3
  } cmd_e;

  // classified transaction passed from the front end to the core
  typedef struct packed {
    logic       has_byte;
    logic       finish;
    logic [7:0] data;
  } op_t;

  localparam logic [255:0] InitHash = {
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[idx];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

@@ rtl/sbsh_stream_if.sv @@
// ----------------------------------------------------------------------------
// sbsh_stream_if
// Valid/ready channel carrying a generic packed payload.
// ----------------------------------------------------------------------------
interface sbsh_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/sbsh_front.sv @@
// ----------------------------------------------------------------------------
// sbsh_front
// Accepts command transactions, classifies them and queues them for the core.
// ----------------------------------------------------------------------------
module sbsh_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       cmd_i,
  input  logic [7:0]       data_byte_i,
  output logic             op_valid_o,
  input  logic             op_ready_i,
  output sbsh_pkg::op_t    op_o
);
  import sbsh_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  op_t               mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     count_q;
  op_t               op_new;
  logic              push, pop, keep;

  // decode the command; the unused code is dropped at the door
  always_comb begin
    op_new      = '0;
    op_new.data = data_byte_i;
    keep        = 1'b1;
    unique case (cmd_e'(cmd_i))
      CMD_ABSORB:        op_new.has_byte = 1'b1;
      CMD_ABSORB_FINISH: begin
        op_new.has_byte = 1'b1;
        op_new.finish   = 1'b1;
      end
      CMD_FINISH:        op_new.finish = 1'b1;
      default:           keep = 1'b0;
    endcase
  end

  assign in_ready_o = (count_q != (PtrW+1)'(QueueDepth));
  assign push       = in_valid_i && in_ready_o && keep;
  assign op_valid_o = (count_q != '0);
  assign pop        = op_valid_o && op_ready_i;
  assign op_o       = mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= op_new;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == (PtrW+1)'(QueueDepth) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> !pop) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + 1'b1) else $error("count slip");

endmodule

@@ rtl/sbsh_core.sv @@
// ----------------------------------------------------------------------------
// sbsh_core
// Block buffer, length counter, padding, 64-round compression and digest out.
// ----------------------------------------------------------------------------
module sbsh_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  output logic          op_ready_o,
  input  sbsh_pkg::op_t op_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    digest_byte_o,
  output logic          last_byte_o
);
  import sbsh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } state_e;

  state_e        state_q;
  logic [5:0]    fill_q;
  logic [63:0]   bits_q;
  logic [255:0]  chain_q;
  logic [255:0]  work_q;
  logic [31:0]   w_q [16];
  logic [5:0]    rnd_q;
  logic          finishing_q, len_blk_q, done_last_q, full_q;
  logic [4:0]    out_idx_q;

  logic [31:0] a, b, c, d, e, f, g, h, t1, t2, w_new, x, y;
  logic [31:0] chain_w [8];
  logic [31:0] pad_w [16];
  logic        pad_room;

  // one compression round plus the schedule extension
  always_comb begin
    {a, b, c, d, e, f, g, h} = work_q;
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + round_k(rnd_q) + w_q[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    x  = w_q[1];
    y  = w_q[14];
    w_new = (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10)) + w_q[9]
            + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w_q[0];
    for (int i = 0; i < 8; i++) chain_w[i] = chain_q[255-32*i -: 32];
  end

  // padded form of the block held in the schedule words
  always_comb begin
    pad_room = (fill_q <= 6'd55) || len_blk_q;
    for (int wi = 0; wi < 16; wi++) begin
      for (int bi = 0; bi < 4; bi++) begin
        if (len_blk_q || ((4*wi + bi) > int'(fill_q)))
          pad_w[wi][31-8*bi -: 8] = 8'h00;
        else if ((4*wi + bi) == int'(fill_q))
          pad_w[wi][31-8*bi -: 8] = PadByte;
        else
          pad_w[wi][31-8*bi -: 8] = w_q[wi][31-8*bi -: 8];
      end
    end
    // big-endian bit length in the last eight bytes
    if (pad_room) begin
      pad_w[14] = bits_q[63:32];
      pad_w[15] = bits_q[31:0];
    end
  end

  assign op_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_byte_o = chain_w[out_idx_q[4:2]][31 - 8*out_idx_q[1:0] -: 8];
  assign last_byte_o   = (out_idx_q == 5'(DigestBytes - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      bits_q      <= '0;
      chain_q     <= InitHash;
      rnd_q       <= '0;
      finishing_q <= 1'b0;
      len_blk_q   <= 1'b0;
      done_last_q <= 1'b0;
      full_q      <= 1'b0;
      out_idx_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (op_valid_i) begin
            finishing_q <= op_i.finish;
            if (op_i.has_byte) begin
              // bytes land big-endian straight in the schedule words
              w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= op_i.data;
              bits_q <= bits_q + 64'd8;
              fill_q <= fill_q + 1'b1;
              if (fill_q == 6'd63) begin
                len_blk_q <= 1'b0;
                full_q    <= 1'b1;
                state_q   <= ST_PAD;  // block full: schedule already loaded
              end else if (op_i.finish) begin
                state_q <= ST_PAD;
              end
            end else if (op_i.finish) begin
              state_q <= ST_PAD;
            end
          end
        end
        // set up a full block, or build the final block(s) with padding, then start the rounds
        ST_PAD: begin
          if (full_q) begin
            // plain full block
            full_q    <= 1'b0;
            len_blk_q <= 1'b0;
          end else begin
            for (int i = 0; i < 16; i++) w_q[i] <= pad_w[i];
            len_blk_q   <= !pad_room;
            done_last_q <= pad_room;
          end
          work_q  <= chain_q;
          rnd_q   <= '0;
          state_q <= ST_COMP;
        end
        ST_COMP: begin
          work_q <= {t1 + t2, a, b, c, d + t1, e, f, g};
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= w_new;
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == 6'd63) state_q <= ST_FOLD;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++)
            chain_q[255-32*i -: 32] <= chain_w[i] + work_q[255-32*i -: 32];
          if (!finishing_q) begin
            state_q <= ST_IDLE;
          end else if (fill_q == '0 && !len_blk_q && !done_last_q) begin
            // a full block ended the message: pad into a fresh block
            state_q <= ST_PAD;
          end else if (len_blk_q) begin
            state_q <= ST_PAD;
          end else begin
            out_idx_q <= '0;
            state_q   <= ST_OUT;
          end
          if (len_blk_q) done_last_q <= 1'b0;
        end
        ST_OUT: begin
          if (out_ready_i) begin
            out_idx_q <= out_idx_q + 1'b1;
            if (last_byte_o) begin
              chain_q     <= InitHash;
              fill_q      <= '0;
              bits_q      <= '0;
              finishing_q <= 1'b0;
              done_last_q <= 1'b0;
              len_blk_q   <= 1'b0;
              state_q     <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_idx_q))
    else $error("digest moved under stall");
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COMP && rnd_q == 6'd63 |=> state_q == ST_FOLD)
    else $error("round count slip");
  a_reset_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_byte_o |=> chain_q == InitHash && bits_q == '0)
    else $error("chain not reinitialized");

endmodule

@@ rtl/sha256_byte_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream with finish command and 32-byte digest output.
// ----------------------------------------------------------------------------
// Usage: in_if carries {cmd, data_byte}; cmd 0 absorbs a byte, 1 absorbs and
// finishes, 2 finishes without a byte, 3 is dropped. out_if returns 32
// digest-byte transactions, word 0 MSB first, last_byte set on the 32nd.
// A four-entry queue decouples the input from the core, so bytes are taken
// one per cycle until it fills. The core takes one byte per cycle while it
// is idle, and each full block passes through a schedule load, 64 rounds
// at one SHA round per cycle, and one fold step. A finish costs one or two
// such blocks, after which the digest streams out one byte per cycle when
// the receiver is ready. A stalled receiver holds the current digest byte;
// the queue keeps taking input until full. Reset restores the initial hash
// values, clears the length and fill counts, and empties the queue.
module sha256_byte_stream_hasher (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbsh_stream_if.sink   in_if,
  sbsh_stream_if.source out_if
);
  import sbsh_pkg::*;

  logic  op_valid, op_ready;
  op_t   op;
  logic [9:0] in_pl;
  logic [8:0] out_pl;

  assign in_pl = in_if.payload;

  sbsh_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .cmd_i      (in_pl[9:8]),
    .data_byte_i(in_pl[7:0]),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op)
  );

  sbsh_core u_core (
    .clk_i, .rst_ni,
    .op_valid_i   (op_valid),
    .op_ready_o   (op_ready),
    .op_i         (op),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .digest_byte_o(out_pl[8:1]),
    .last_byte_o  (out_pl[0])
  );

  assign out_if.payload = out_pl;

endmodule
